// ----- hw/rtl/sjfk_pkg.sv -----
// Package for the six-joint forward kinematics block: defaults, register codes, arctan table.
`default_nettype none
package sjfk_pkg;

    localparam int DEF_ANGLE_BITS      = 16;
    localparam int DEF_FRAC_BITS       = 16;
    localparam int DEF_TRIG_ITERATIONS = 16;

    localparam int NUM_JOINTS  = 6;
    localparam int ANGLE_W     = 16;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_OUT     = 12;
    localparam int ATAN_LEN    = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRIST        = 3'd5;

    localparam logic [CFG_W-1:0] RST_BASE_HEIGHT = 17'd7176;
    localparam logic [CFG_W-1:0] RST_SHOULDER_X  = 17'd4588;
    localparam logic [CFG_W-1:0] RST_SHOULDER_Y  = 17'd15892;
    localparam logic [CFG_W-1:0] RST_UPPER_ARM   = 17'd23593;
    localparam logic [CFG_W-1:0] RST_FOREARM     = 17'd14320;
    localparam logic [CFG_W-1:0] RST_WRIST       = 17'd10584;

    // CORDIC start value, gain-compensated, Q2.30
    localparam int CORDIC_START = 652032874;

    // atan(2^-i) in units of 2^-32 turn
    localparam int ATAN_TURN32 [ATAN_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

endpackage
`default_nettype wire

// ----- hw/rtl/six_joint_forward_kinematics.sv -----
// Top level: pipelined CORDIC trig and chained joint transforms for a six-joint arm.
//
//  channel | direction | handshake         | payload
//  s_*     | in        | s_tvalid/s_tready | s_tdata: joint1..joint6 angle, 16 bits each
//  m_*     | out       | m_tvalid/m_tready | m_tdata: rot r1c1..r3c3, pos x,y,z
//  cfg_*   | in        | cfg_valid/ready   | cfg_index, cfg_data (17 bits)
//
// The angles are registered with their quadrant, then come the CORDIC iterations,
// one per stage, then one stage for rounding and quadrant, five for the transform
// products (one per joint after the first) and the output register. One transfer
// per cycle is sustained while m_tready is high. Each stage holds its valid bit and
// moves only when the stage after it is empty or moving, so a stall fills bubbles
// first. Reset clears the valid bits and loads the default link offsets.
`default_nettype none
module six_joint_forward_kinematics
    import sjfk_pkg::*;
#(
    parameter int ANGLE_BITS      = DEF_ANGLE_BITS,
    parameter int FRAC_BITS       = DEF_FRAC_BITS,
    parameter int TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // joint1_angle [15:0] .. joint6_angle [95:80]
    input  wire logic [NUM_JOINTS*ANGLE_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // rot_r1c1, rot_r1c2, rot_r1c3, rot_r2c1 .. rot_r3c3, pos_x, pos_y, pos_z,
    // FRAC_BITS+2 bits each from bit 0 up, zero padded to bytes
    output logic [((NUM_OUT*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    localparam int N      = (TRIG_ITERATIONS < ATAN_LEN) ? TRIG_ITERATIONS : ATAN_LEN;
    localparam int CW     = 33;
    localparam int R      = 30 - FRAC_BITS;
    localparam int CSW    = FRAC_BITS + 2;
    localparam int OW     = FRAC_BITS + 2;
    localparam int IW     = ((FRAC_BITS > CFG_W) ? FRAC_BITS : CFG_W) + 6;
    localparam int PW     = 2 * IW + 2;
    localparam int OUT_DW = ((NUM_OUT * OW + 7) / 8) * 8;
    localparam int TS     = N + 1;
    localparam int OS     = N + 7;
    localparam int L      = N + 8;

    localparam logic signed [CW-1:0]  HALF_C = CW'(1) << (R - 1);
    localparam logic signed [CW-1:0]  ONE_C  = CW'(1) << FRAC_BITS;
    localparam logic signed [CSW-1:0] ONE_S  = CSW'(1) << FRAC_BITS;
    localparam logic signed [IW-1:0]  ONE_I  = IW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0]  HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [IW-1:0]  OMAX   = IW'((1 << (OW - 1)) - 1);
    localparam logic signed [IW-1:0]  OMIN   = -OMAX - IW'(1);

    typedef struct packed {
        logic [8:0][IW-1:0] r;
        logic [2:0][IW-1:0] t;
    } pose_t;

    typedef logic [NUM_JOINTS-1:0][CSW-1:0] trig_t;

    // Configuration registers
    logic [CFG_W-1:0] cfg_reg [0:NUM_JOINTS-1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= RST_BASE_HEIGHT;
            cfg_reg[1] <= RST_SHOULDER_X;
            cfg_reg[2] <= RST_SHOULDER_Y;
            cfg_reg[3] <= RST_UPPER_ARM;
            cfg_reg[4] <= RST_FOREARM;
            cfg_reg[5] <= RST_WRIST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_HEIGHT: cfg_reg[0] <= cfg_data;
                REG_SHOULDER_X:  cfg_reg[1] <= cfg_data;
                REG_SHOULDER_Y:  cfg_reg[2] <= cfg_data;
                REG_UPPER_ARM:   cfg_reg[3] <= cfg_data;
                REG_FOREARM:     cfg_reg[4] <= cfg_data;
                REG_WRIST:       cfg_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valids and per-stage advance
    logic [L-1:0] v_reg;
    logic [L-1:0] v_next;
    logic [L-1:0] en;

    always_comb
    begin
        en[L-1] = !v_reg[L-1] || m_tready;
        for (int k = L - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[0] = s_tvalid;
        for (int k = 1; k < L; k++)
            v_next[k] = v_reg[k-1];
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < L; k++)
                if (en[k])
                    v_reg[k] <= v_next[k];
        end
    end

    // CORDIC pipeline, one iteration per stage
    logic signed [CW-1:0] cx_reg [0:N][0:NUM_JOINTS-1];
    logic signed [CW-1:0] cy_reg [0:N][0:NUM_JOINTS-1];
    logic signed [CW-1:0] cz_reg [0:N][0:NUM_JOINTS-1];
    logic [1:0]           cq_reg [0:N][0:NUM_JOINTS-1];

    genvar gj, gi, gk;
    generate
        for (gj = 0; gj < NUM_JOINTS; gj++)
        begin : g_joint
            logic [31:0] a32_next;
            logic [31:0] ofs_next;
            logic [1:0]  q_next;
            logic [31:0] res_next;

            // quadrant by the top bits after an eighth-turn offset
            always_comb
            begin
                a32_next = ({16'b0, s_tdata[gj*ANGLE_W +: ANGLE_W]}
                            & 32'((64'd1 << ANGLE_BITS) - 64'd1)) << (32 - ANGLE_BITS);
                ofs_next = a32_next + 32'h2000_0000;
                q_next   = ofs_next[31:30];
                res_next = a32_next - {q_next, 30'b0};
            end

            always_ff @(posedge clk)
            begin
                if (en[0])
                begin
                    cx_reg[0][gj] <= CW'(CORDIC_START);
                    cy_reg[0][gj] <= '0;
                    cz_reg[0][gj] <= CW'($signed(res_next));
                    cq_reg[0][gj] <= q_next;
                end
            end

            for (gi = 1; gi <= N; gi++)
            begin : g_iter
                logic signed [CW-1:0] x_next, y_next, z_next;

                always_comb
                begin
                    if (!cz_reg[gi-1][gj][CW-1])
                    begin
                        x_next = cx_reg[gi-1][gj] - (cy_reg[gi-1][gj] >>> (gi - 1));
                        y_next = cy_reg[gi-1][gj] + (cx_reg[gi-1][gj] >>> (gi - 1));
                        z_next = cz_reg[gi-1][gj] - CW'(ATAN_TURN32[gi-1]);
                    end
                    else
                    begin
                        x_next = cx_reg[gi-1][gj] + (cy_reg[gi-1][gj] >>> (gi - 1));
                        y_next = cy_reg[gi-1][gj] - (cx_reg[gi-1][gj] >>> (gi - 1));
                        z_next = cz_reg[gi-1][gj] + CW'(ATAN_TURN32[gi-1]);
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[gi])
                    begin
                        cx_reg[gi][gj] <= x_next;
                        cy_reg[gi][gj] <= y_next;
                        cz_reg[gi][gj] <= z_next;
                        cq_reg[gi][gj] <= cq_reg[gi-1][gj];
                    end
                end
            end
        end
    endgenerate

    // Round, clamp and turn by quadrant; trig values then ride along the chain
    trig_t cos_reg [0:4];
    trig_t sin_reg [0:4];
    trig_t cos_next, sin_next;

    always_comb
    begin
        logic signed [CW-1:0]  rx, ry;
        logic signed [CSW-1:0] c, s;
        for (int j = 0; j < NUM_JOINTS; j++)
        begin
            rx = (cx_reg[N][j] + HALF_C) >>> R;
            ry = (cy_reg[N][j] + HALF_C) >>> R;
            if (rx > ONE_C)       c = ONE_S;
            else if (rx < -ONE_C) c = -ONE_S;
            else                  c = CSW'(rx);
            if (ry > ONE_C)       s = ONE_S;
            else if (ry < -ONE_C) s = -ONE_S;
            else                  s = CSW'(ry);
            case (cq_reg[N][j])
                2'd0:    begin cos_next[j] = c;  sin_next[j] = s;  end
                2'd1:    begin cos_next[j] = -s; sin_next[j] = c;  end
                2'd2:    begin cos_next[j] = -c; sin_next[j] = -s; end
                default: begin cos_next[j] = s;  sin_next[j] = -c; end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[TS])
        begin
            cos_reg[0] <= cos_next;
            sin_reg[0] <= sin_next;
        end
    end

    function automatic logic signed [IW-1:0] ext(input logic signed [CSW-1:0] v);
        return IW'(v);
    endfunction

    function automatic logic signed [IW-1:0] len(input logic [CFG_W-1:0] v);
        return IW'(v);
    endfunction

    // acc * j, each entry one rounding of a three-term sum
    function automatic pose_t compose(input pose_t a, input pose_t j);
        pose_t                o;
        logic signed [PW-1:0] sum;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum = PW'($signed(a.r[r*3]) * $signed(j.r[c]))
                    + PW'($signed(a.r[r*3+1]) * $signed(j.r[3+c]))
                    + PW'($signed(a.r[r*3+2]) * $signed(j.r[6+c]))
                    + HALF_P;
                o.r[r*3+c] = IW'(sum >>> FRAC_BITS);
            end
            sum = PW'($signed(a.r[r*3]) * $signed(j.t[0]))
                + PW'($signed(a.r[r*3+1]) * $signed(j.t[1]))
                + PW'($signed(a.r[r*3+2]) * $signed(j.t[2]))
                + HALF_P;
            o.t[r] = IW'(sum >>> FRAC_BITS) + a.t[r];
        end
        return o;
    endfunction

    // Transform chain: one joint per stage
    pose_t pose_reg [0:4];

    generate
        for (gk = 0; gk < 5; gk++)
        begin : g_chain
            pose_t acc_src, jnt, pose_next;
            logic signed [IW-1:0] c, s;

            // first stage builds the base joint pose, later stages take the previous one
            if (gk == 0)
            begin : g_first
                always_comb
                begin
                    acc_src.r = {IW'(0), -ONE_I, IW'(0),
                                 ext(cos_reg[0][0]), IW'(0), ext(sin_reg[0][0]),
                                 -ext(sin_reg[0][0]), IW'(0), ext(cos_reg[0][0])};
                    acc_src.t = {len(cfg_reg[0]), IW'(0), IW'(0)};
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    acc_src = pose_reg[gk-1];
                end
            end

            always_comb
            begin
                c = ext(cos_reg[gk][gk+1]);
                s = ext(sin_reg[gk][gk+1]);
                jnt = '0;
                case (gk)
                    0:
                    begin
                        jnt.r = {ONE_I, IW'(0), IW'(0), IW'(0), c, s, IW'(0), -s, c};
                        jnt.t = {IW'(0), -len(cfg_reg[2]), len(cfg_reg[1])};
                    end
                    1:
                    begin
                        jnt.r = {ONE_I, IW'(0), IW'(0), IW'(0), c, s, IW'(0), -s, c};
                        jnt.t = {IW'(0), -len(cfg_reg[3]), IW'(0)};
                    end
                    2:
                    begin
                        jnt.r = {c, s, IW'(0), -s, c, IW'(0), IW'(0), IW'(0), ONE_I};
                        jnt.t = {IW'(0), IW'(0), len(cfg_reg[4])};
                    end
                    3:
                    begin
                        jnt.r = {ONE_I, IW'(0), IW'(0), IW'(0), c, -s, IW'(0), s, c};
                        jnt.t = {IW'(0), IW'(0), len(cfg_reg[5])};
                    end
                    default:
                    begin
                        jnt.r = {c, s, IW'(0), -s, c, IW'(0), IW'(0), IW'(0), ONE_I};
                        jnt.t = '0;
                    end
                endcase
                pose_next = compose(acc_src, jnt);
            end

            always_ff @(posedge clk)
            begin
                if (en[TS+1+gk])
                    pose_reg[gk] <= pose_next;
            end

            if (gk < 4)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en[TS+1+gk])
                    begin
                        cos_reg[gk+1] <= cos_reg[gk];
                        sin_reg[gk+1] <= sin_reg[gk];
                    end
                end
            end
        end
    endgenerate

    // Output register with saturation
    logic [OUT_DW-1:0] out_data_reg;
    logic [OUT_DW-1:0] out_data_next;

    function automatic logic [OW-1:0] sat(input logic signed [IW-1:0] v);
        if (v > OMAX)      return OW'(OMAX);
        else if (v < OMIN) return OW'(OMIN);
        else               return OW'(v);
    endfunction

    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < 9; i++)
            out_data_next[i*OW +: OW] = sat($signed(pose_reg[4].r[i]));
        for (int i = 0; i < 3; i++)
            out_data_next[(9+i)*OW +: OW] = sat($signed(pose_reg[4].t[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en[OS])
            out_data_reg <= out_data_next;
    end

    assign m_tdata = out_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/sjfk_checker.sv -----
// Port-level checker for the forward kinematics block, bound to the top level.
`default_nettype none
module sjfk_checker
    import sjfk_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((NUM_OUT*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    // stalled result holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only backs up when the output is stalled
    a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked without output stall");

    // an open output drains the whole pipeline by one
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output ready");

    // configuration writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind six_joint_forward_kinematics sjfk_checker #(.FRAC_BITS(FRAC_BITS)) u_sjfk_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire
